FILE: rtl/core/pwbd_pkg.sv
`default_nettype none

package pwbd_pkg;

   localparam int unsigned TICK_W = 16;
   localparam int unsigned COUNT_W = TICK_W + 1;
   localparam int unsigned APB_DATA_W = 32;
   localparam int unsigned APB_ADDR_W = 3;

   localparam logic [TICK_W-1:0] DEFAULT_TIMEOUT_TICKS = 16'd1000;

   // register index, taken from paddr[2]
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      PH_WAIT_LOW  = 3'b001,
      PH_WAIT_RISE = 3'b010,
      PH_MEASURE   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_TIMEOUT_LOW  = 2'd1,
      ST_TIMEOUT_RISE = 2'd2,
      ST_TIMEOUT_FALL = 2'd3
   } status_type;

   typedef struct packed {
      logic [TICK_W-1:0] threshold;
      logic [TICK_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic bit_value;
      status_type status;
      logic [TICK_W-1:0] high_width;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/pwbd_csr.sv
`default_nettype none

module pwbd_csr #(
   parameter logic [pwbd_pkg::TICK_W-1:0] DefaultTimeout = pwbd_pkg::DEFAULT_TIMEOUT_TICKS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [pwbd_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [pwbd_pkg::APB_DATA_W-1:0] pwdata,
   output logic [pwbd_pkg::APB_DATA_W-1:0] prdata,
   output logic pready,
   output pwbd_pkg::cfg_type cfg
);
   import pwbd_pkg::*;

   logic [TICK_W-1:0] threshold_ff, threshold_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;
   logic [TICK_W-1:0] limit_ff, limit_in;
   logic wr_en;
   logic reg_sel;

   assign pready = 1'b1;
   assign wr_en = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_comb begin
      threshold_in = threshold_ff;
      timeout_in = timeout_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_THRESHOLD: begin
               threshold_in = pwdata[TICK_W-1:0];
            end
            REG_TIMEOUT: begin
               timeout_in = pwdata[TICK_W-1:0];
               // zero picks the built-in limit
               limit_in = (pwdata[TICK_W-1:0] == '0) ? DefaultTimeout : pwdata[TICK_W-1:0];
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         timeout_ff <= '0;
         limit_ff <= DefaultTimeout;
      end else begin
         threshold_ff <= threshold_in;
         timeout_ff <= timeout_in;
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_THRESHOLD: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, threshold_ff};
         REG_TIMEOUT:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, timeout_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.limit = limit_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pwbd_decode.sv
`default_nettype none

module pwbd_decode (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic line_level,
   input  wire pwbd_pkg::cfg_type cfg,
   output logic res_valid,
   output pwbd_pkg::result_type res
);
   import pwbd_pkg::*;

   phase_type phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_inc;
   logic over_limit;

   assign count_inc = count_ff + COUNT_W'(1);
   assign over_limit = count_inc > {1'b0, cfg.limit};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      res_valid = 1'b0;
      res.bit_value = 1'b0;
      res.status = ST_OK;
      res.high_width = '0;
      unique case (phase_ff)
         PH_WAIT_RISE: begin
            if (line_level) begin
               phase_in = PH_MEASURE;
               count_in = COUNT_W'(1);
            end else if (over_limit) begin
               res_valid = 1'b1;
               res.status = ST_TIMEOUT_RISE;
            end else begin
               count_in = count_inc;
            end
         end
         PH_MEASURE: begin
            if (!line_level) begin
               // falling edge ends the pulse
               res_valid = 1'b1;
               res.bit_value = count_ff > {1'b0, cfg.threshold};
               res.high_width = count_ff[TICK_W-1:0];
            end else if (over_limit) begin
               res_valid = 1'b1;
               res.status = ST_TIMEOUT_FALL;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            if (!line_level) begin
               phase_in = PH_WAIT_RISE;
               count_in = '0;
            end else if (over_limit) begin
               res_valid = 1'b1;
               res.status = ST_TIMEOUT_LOW;
            end else begin
               count_in = count_inc;
            end
         end
      endcase
      if (res_valid) begin
         phase_in = PH_WAIT_LOW;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_LOW;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/pwbd_out_buf.sv
`default_nettype none

module pwbd_out_buf (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire pwbd_pkg::result_type push_data,
   output logic full,
   output logic out_valid,
   input  wire logic out_stall,
   output pwbd_pkg::result_type out_data
);
   import pwbd_pkg::*;

   logic out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no push while the skid stage is full
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pulse_width_bit_decoder_core.sv
// Pulse-width bit decoder. Each req beat carries one sampled line level (one tick). The block
// waits for the line to go low, then for a rising edge, then counts high ticks until the line
// falls, and returns one rsp beat per decoded bit: status ok, the bit (width above
// threshold_ticks) and the high width in ticks. A phase that runs past the tick limit returns
// a timeout status naming that phase, with bit and width zero, and the decoder restarts. A
// timeout_ticks of zero selects DefaultTimeout. Timing: one sample is taken every cycle while
// req_stall is low; the phase/count update is a single registered step, and each result is
// registered before it reaches rsp. An output register plus a one-entry skid stage hold
// results, so req_stall rises only when both are occupied, i.e. after rsp has been stalled
// with two results pending. Registers: threshold_ticks at byte address 0, timeout_ticks at 4.
`default_nettype none

module pulse_width_bit_decoder_core #(
   parameter logic [pwbd_pkg::TICK_W-1:0] DefaultTimeout = pwbd_pkg::DEFAULT_TIMEOUT_TICKS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_line_level,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic rsp_bit_value,
   output logic [1:0] rsp_status,
   output logic [pwbd_pkg::TICK_W-1:0] rsp_high_width,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [pwbd_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [pwbd_pkg::APB_DATA_W-1:0] pwdata,
   output logic [pwbd_pkg::APB_DATA_W-1:0] prdata,
   output logic pready
);
   import pwbd_pkg::*;

   cfg_type cfg;
   result_type dec_res;
   result_type out_res;
   logic dec_valid;
   logic accept;
   logic buf_full;

   assign req_stall = buf_full;
   assign accept = req_valid & !req_stall;

   pwbd_csr #(
      .DefaultTimeout(DefaultTimeout)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .cfg(cfg)
   );

   pwbd_decode u_decode (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .line_level(req_line_level),
      .cfg(cfg),
      .res_valid(dec_valid),
      .res(dec_res)
   );

   pwbd_out_buf u_out_buf (
      .clock(clock),
      .reset(reset),
      .push(accept & dec_valid),
      .push_data(dec_res),
      .full(buf_full),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data(out_res)
   );

   assign rsp_bit_value = out_res.bit_value;
   assign rsp_status = out_res.status;
   assign rsp_high_width = out_res.high_width;

   // a filled skid stage always sits behind a pending output beat
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("skid stage holds a beat while output is empty");

   // the skid stage only fills while the output beat was stalled
   assert property (@(posedge clock) disable iff (reset) $rose(req_stall) |-> $past(rsp_stall))
      else $error("skid stage filled without a stall");

   // timeouts carry no bit and no width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_high_width == '0) && !rsp_bit_value)
      else $error("timeout beat with nonzero payload");

   // a decoded pulse is at least one tick wide
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> (rsp_high_width != '0))
      else $error("decoded pulse of zero width");

endmodule

`default_nettype wire
